### sv/umrb_pkg.sv
// shared types and constants for the unacked message retransmit buffer
// no dependencies

package umrb_pkg;

  localparam int unsigned SLOTS   = 16;
  localparam int unsigned SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W   = $clog2(SLOTS + 1);

  localparam int unsigned ID_W   = 32;
  localparam int unsigned TIME_W = 64;
  localparam int unsigned BODY_W = 64;
  localparam int unsigned LIM_W  = 5;
  localparam int unsigned SRC_W  = 3;
  localparam int unsigned LIMC_W = (CNT_W > LIM_W) ? CNT_W : LIM_W;

  localparam logic [CNT_W-1:0]   SLOTS_C  = CNT_W'(SLOTS);
  localparam logic [SLOT_AW-1:0] LAST_IDX = SLOT_AW'(SLOTS - 1);
  localparam logic [LIM_W-1:0]   LIM_RST  = LIM_W'(16);

  localparam logic [SRC_W-1:0] SRC_CUR_SENT = 3'd0;
  localparam logic [SRC_W-1:0] SRC_RESENT   = 3'd1;
  localparam logic [SRC_W-1:0] SRC_ACK_CUR  = 3'd2;
  localparam logic [SRC_W-1:0] SRC_ACK_SLOT = 3'd3;
  localparam logic [SRC_W-1:0] SRC_ACK_NONE = 3'd4;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] tstamp;
    logic [BODY_W-1:0] body;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

endpackage

### sv/umrb_ram.sv
// simple dual port ram, one write and one registered read port
// no dependencies

module umrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### sv/unacked_message_retransmit_buffer.sv
// Retransmit buffer: holds the current outgoing message and a store of unacked
// messages in a slot ram, scanned one slot per cycle through its read port.
// A send word resends up to drain_limit slots (clamped to 1..16), after
// finding the oldest slot to evict when the store is full; an ack word needs
// no slot scan when it matches the current message and otherwise scans the
// slots. busy is high while either is under way. Results appear at most one
// per cycle on res_strobe_o and cannot be held off by the receiver.
// depends on umrb_pkg and umrb_ram

module unacked_message_retransmit_buffer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [umrb_pkg::LIM_W-1:0]    cfg_wdata_i,
  input  logic                          start,
  output logic                          busy,
  input  logic                          kind_i,
  input  logic [umrb_pkg::ID_W-1:0]     msg_id_i,
  input  logic [umrb_pkg::TIME_W-1:0]   msg_time_i,
  input  logic [umrb_pkg::BODY_W-1:0]   payload_i,
  output logic                          res_strobe_o,
  output logic [umrb_pkg::ID_W-1:0]     out_id_o,
  output logic [umrb_pkg::TIME_W-1:0]   out_time_o,
  output logic [umrb_pkg::BODY_W-1:0]   out_payload_o,
  output logic [umrb_pkg::SRC_W-1:0]    source_o,
  output logic                          last_o
);

  import umrb_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_OLD   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_ACK   = 3'd3;

  logic [2:0]         state_q;
  logic [LIM_W-1:0]   dl_q;
  logic [CNT_W-1:0]   lim_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               pend_q;
  logic [SLOT_AW-1:0] pidx_q;
  logic [TIME_W-1:0]  best_q;
  logic [SLOT_AW-1:0] bidx_q;
  logic [SLOTS-1:0]   valid_q;
  logic [SLOTS-1:0]   written_q;

  logic               cur_valid_q;
  logic [ID_W-1:0]    cur_id_q;
  logic [TIME_W-1:0]  cur_time_q;
  logic [BODY_W-1:0]  cur_body_q;

  logic [ID_W-1:0]    in_id_q;
  logic [TIME_W-1:0]  in_time_q;
  logic [BODY_W-1:0]  in_body_q;

  logic               ram_we;
  logic [SLOT_AW-1:0] ram_waddr;
  slot_t              ram_wdata;
  logic               ram_re;
  logic [SLOT_AW-1:0] ram_raddr;
  logic [SLOT_W-1:0]  ram_rdata;
  slot_t              rd;

  logic               accept;
  logic               any_free;
  logic [SLOT_AW-1:0] free_idx;
  logic [LIMC_W-1:0]  lim_ext;
  logic [CNT_W-1:0]   lim_d;
  logic               hit;
  logic [ID_W-1:0]    rd_id;

  logic               em_valid;
  logic [ID_W-1:0]    em_id;
  logic [TIME_W-1:0]  em_time;
  logic [BODY_W-1:0]  em_body;
  logic [SRC_W-1:0]   em_src;
  logic               em_last;

  umrb_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOTS),
    .AW    (SLOT_AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd     = slot_t'(ram_rdata);
  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign rd_id  = written_q[pidx_q] ? rd.id : '0;
  assign hit    = (rd_id == in_id_q);

  // first free slot, lowest index wins
  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = SLOT_AW'(i);
      end
    end
  end
  assign any_free = ~&valid_q;

  always_comb begin
    lim_ext = LIMC_W'(dl_q);
    if (lim_ext == '0) begin
      lim_ext = LIMC_W'(1);
    end
    if (lim_ext > LIMC_W'(SLOTS)) begin
      lim_ext = LIMC_W'(SLOTS);
    end
    lim_d = CNT_W'(lim_ext);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = free_idx;
    ram_wdata = '{id: cur_id_q, tstamp: cur_time_q, body: cur_body_q};
    ram_re    = 1'b0;
    ram_raddr = cnt_q[SLOT_AW-1:0];
    case (state_q)
      S_IDLE: begin
        ram_we = accept && !kind_i && cur_valid_q && any_free;
      end
      S_OLD: begin
        ram_re    = (cnt_q < SLOTS_C);
        ram_we    = !pend_q && (cnt_q == SLOTS_C);
        ram_waddr = bidx_q;
      end
      S_ACK: begin
        ram_re = (cnt_q < SLOTS_C) && !(pend_q && hit);
      end
      S_DRAIN: begin
        ram_re    = (cnt_q < lim_q);
        ram_raddr = LAST_IDX - cnt_q[SLOT_AW-1:0];
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  always_comb begin
    em_valid = 1'b0;
    em_id    = in_id_q;
    em_time  = '0;
    em_body  = '0;
    em_src   = SRC_ACK_NONE;
    em_last  = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (accept && kind_i && (cur_id_q == msg_id_i)) begin
          em_valid = 1'b1;
          em_id    = msg_id_i;
          em_src   = SRC_ACK_CUR;
        end
      end
      S_ACK: begin
        if (pend_q && hit) begin
          em_valid = 1'b1;
          em_src   = SRC_ACK_SLOT;
        end else if (!pend_q && (cnt_q == SLOTS_C)) begin
          em_valid = 1'b1;
          em_src   = SRC_ACK_NONE;
        end
      end
      S_DRAIN: begin
        if (pend_q && valid_q[pidx_q]) begin
          em_valid = 1'b1;
          em_id    = rd.id;
          em_time  = rd.tstamp;
          em_body  = rd.body;
          em_src   = SRC_RESENT;
          em_last  = 1'b0;
        end else if (!pend_q && (cnt_q == lim_q)) begin
          em_valid = 1'b1;
          em_time  = in_time_q;
          em_body  = in_body_q;
          em_src   = SRC_CUR_SENT;
        end
      end
      default: begin
        em_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      dl_q          <= LIM_RST;
      lim_q         <= '0;
      cnt_q         <= '0;
      pend_q        <= 1'b0;
      pidx_q        <= '0;
      best_q        <= '0;
      bidx_q        <= '0;
      valid_q       <= '0;
      written_q     <= '0;
      cur_valid_q   <= 1'b0;
      cur_id_q      <= '0;
      cur_time_q    <= '0;
      cur_body_q    <= '0;
      in_id_q       <= '0;
      in_time_q     <= '0;
      in_body_q     <= '0;
      res_strobe_o  <= 1'b0;
      out_id_o      <= '0;
      out_time_o    <= '0;
      out_payload_o <= '0;
      source_o      <= '0;
      last_o        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dl_q <= cfg_wdata_i;
      end

      // slot reads issue one per cycle, data checked in the cycle after the read
      if (ram_re) begin
        cnt_q  <= cnt_q + CNT_W'(1);
        pend_q <= 1'b1;
        pidx_q <= ram_raddr;
      end else begin
        pend_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            in_id_q   <= msg_id_i;
            in_time_q <= msg_time_i;
            in_body_q <= payload_i;
            cnt_q     <= '0;
            lim_q     <= lim_d;
            if (kind_i) begin
              if (cur_id_q == msg_id_i) begin
                cur_valid_q <= 1'b0;
              end else begin
                state_q <= S_ACK;
              end
            end else if (cur_valid_q && !any_free) begin
              state_q <= S_OLD;
            end else begin
              if (cur_valid_q) begin
                valid_q[free_idx]   <= 1'b1;
                written_q[free_idx] <= 1'b1;
              end
              state_q <= S_DRAIN;
            end
          end
        end
        S_OLD: begin
          if (pend_q && ((pidx_q == '0) || (rd.tstamp < best_q))) begin
            best_q <= rd.tstamp;
            bidx_q <= pidx_q;
          end
          if (ram_we) begin
            valid_q[bidx_q]   <= 1'b1;
            written_q[bidx_q] <= 1'b1;
            cnt_q             <= '0;
            state_q           <= S_DRAIN;
          end
        end
        S_ACK: begin
          if (pend_q && hit) begin
            valid_q[pidx_q] <= 1'b0;
            state_q         <= S_IDLE;
          end else if (!pend_q && (cnt_q == SLOTS_C)) begin
            state_q <= S_IDLE;
          end
        end
        S_DRAIN: begin
          if (!pend_q && (cnt_q == lim_q)) begin
            cur_valid_q <= 1'b1;
            cur_id_q    <= in_id_q;
            cur_time_q  <= in_time_q;
            cur_body_q  <= in_body_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase

      res_strobe_o <= em_valid;
      if (em_valid) begin
        out_id_o      <= em_id;
        out_time_o    <= em_time;
        out_payload_o <= em_body;
        source_o      <= em_src;
        last_o        <= em_last;
      end
    end
  end

  // the final word of an item leaves the block idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && last_o |-> !busy)
    else $error("last word while busy");

  // no slot read left in flight once idle
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> !pend_q)
    else $error("read pending while idle");

  // the resend pass never runs past its limit
  a_drain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN) |-> (cnt_q <= lim_q) && (lim_q <= SLOTS_C) && (lim_q != '0))
    else $error("resend pass out of range");

  // a non-final word keeps the block busy for the final one
  a_more_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && !last_o |-> busy)
    else $error("resent word with nothing to follow");

endmodule

### tb/sv/unacked_message_retransmit_buffer_tb.sv
// testbench for unacked_message_retransmit_buffer: directed acks, store overflow with
// oldest-slot eviction and random send/ack traffic over several drain limits
// depends on umrb_pkg and the buffer rtl; checks every word against its own buffer model
`timescale 1ns / 100ps

module unacked_message_retransmit_buffer_tb;
  import umrb_pkg::*;

  localparam logic        KIND_SEND = 1'b0;
  localparam logic        KIND_ACK  = 1'b1;
  localparam int unsigned SHOWN_MAX = 10;
  localparam int unsigned POOL_MAX  = 20;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] tstamp;
    logic [BODY_W-1:0] body;
    logic [SRC_W-1:0]  src;
    logic              last;
  } word_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [LIM_W-1:0]    cfg_wdata_i;
  logic                start;
  logic                busy;
  logic                kind_i;
  logic [ID_W-1:0]     msg_id_i;
  logic [TIME_W-1:0]   msg_time_i;
  logic [BODY_W-1:0]   payload_i;
  logic                res_strobe_o;
  logic [ID_W-1:0]     out_id_o;
  logic [TIME_W-1:0]   out_time_o;
  logic [BODY_W-1:0]   out_payload_o;
  logic [SRC_W-1:0]    source_o;
  logic                last_o;

  // buffer model
  logic              buf_valid [SLOTS];
  logic [ID_W-1:0]   buf_id    [SLOTS];
  logic [TIME_W-1:0] buf_time  [SLOTS];
  logic [BODY_W-1:0] buf_body  [SLOTS];
  logic              live_valid;
  logic [ID_W-1:0]   live_id;
  logic [TIME_W-1:0] live_time;
  logic [BODY_W-1:0] live_body;
  logic [LIM_W-1:0]  drain_reg;

  word_t             due_words[$];
  logic [ID_W-1:0]   recent_ids[$];
  logic [TIME_W-1:0] clock_stamp;
  int unsigned       mismatches;
  int unsigned       gap_max;

  unacked_message_retransmit_buffer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind_i),
    .msg_id_i      (msg_id_i),
    .msg_time_i    (msg_time_i),
    .payload_i     (payload_i),
    .res_strobe_o  (res_strobe_o),
    .out_id_o      (out_id_o),
    .out_time_o    (out_time_o),
    .out_payload_o (out_payload_o),
    .source_o      (source_o),
    .last_o        (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic void log_fault(input string what);
    mismatches++;
    if (mismatches <= SHOWN_MAX) begin
      $display("%0t: %s", $realtime, what);
    end
  endfunction

  function automatic void model_ack(input logic [ID_W-1:0] id);
    int hit;
    word_t w;
    hit = -1;
    w = '{id: id, tstamp: '0, body: '0, src: SRC_ACK_NONE, last: 1'b1};
    if (live_id == id) begin
      live_valid = 1'b0;
      w.src = SRC_ACK_CUR;
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        if (hit < 0 && buf_id[i] == id) hit = i;
      end
      if (hit >= 0) begin
        buf_valid[hit] = 1'b0;
        w.src = SRC_ACK_SLOT;
      end
    end
    due_words.push_back(w);
  endfunction

  function automatic void model_send(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] t,
                                     input logic [BODY_W-1:0] b);
    int pick;
    int seen;
    int span;
    // park the unacked current word, evicting the oldest slot when full
    if (live_valid) begin
      pick = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (pick < 0 && !buf_valid[i]) pick = i;
      end
      if (pick < 0) begin
        pick = 0;
        for (int i = 1; i < SLOTS; i++) begin
          if (buf_time[i] < buf_time[pick]) pick = i;
        end
      end
      buf_valid[pick] = 1'b1;
      buf_id[pick]    = live_id;
      buf_time[pick]  = live_time;
      buf_body[pick]  = live_body;
    end
    span = (drain_reg == '0) ? 1 : int'(drain_reg);
    seen = 0;
    for (int i = SLOTS - 1; i >= 0 && seen < span; i--) begin
      seen++;
      if (buf_valid[i]) begin
        due_words.push_back('{id: buf_id[i], tstamp: buf_time[i], body: buf_body[i],
                              src: SRC_RESENT, last: 1'b0});
      end
    end
    live_valid = 1'b1;
    live_id    = id;
    live_time  = t;
    live_body  = b;
    due_words.push_back('{id: id, tstamp: t, body: b, src: SRC_CUR_SENT, last: 1'b1});
  endfunction

  always @(posedge clk_i) begin : check_words
    word_t got;
    word_t exp;
    got = {out_id_o, out_time_o, out_payload_o, source_o, last_o};
    if (rst_ni && res_strobe_o) begin
      if (due_words.size() == 0) begin
        log_fault($sformatf("unexpected word id %h time %h body %h src %0d last %0d",
                            got.id, got.tstamp, got.body, got.src, got.last));
      end else begin
        exp = due_words.pop_front();
        if (got.id !== exp.id || got.tstamp !== exp.tstamp || got.body !== exp.body ||
            got.src !== exp.src || got.last !== exp.last) begin
          log_fault($sformatf({"word mismatch exp id %h time %h body %h src %0d last %0d",
                               " got id %h time %h body %h src %0d last %0d"},
                              exp.id, exp.tstamp, exp.body, exp.src, exp.last,
                              got.id, got.tstamp, got.body, got.src, got.last));
        end
      end
    end
  end

  task automatic send_word(input logic kind, input logic [ID_W-1:0] id,
                           input logic [TIME_W-1:0] t, input logic [BODY_W-1:0] b);
    int unsigned gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start      <= 1'b1;
    kind_i     <= kind;
    msg_id_i   <= id;
    msg_time_i <= t;
    payload_i  <= b;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (kind == KIND_ACK) begin
      model_ack(id);
    end else begin
      model_send(id, t, b);
      recent_ids.push_back(id);
      if (recent_ids.size() > POOL_MAX) void'(recent_ids.pop_front());
    end
  endtask

  // hold off until every expected word is out and the block has gone idle
  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    while (due_words.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_drain(input logic [LIM_W-1:0] lim);
    settle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lim;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    drain_reg = lim;
  endtask

  task automatic test_ack_paths();
    gap_max = 6;
    send_word(KIND_ACK, '0, '0, '0);          // matches the invalid current after reset
    send_word(KIND_ACK, 32'd5, '1, '1);       // no match anywhere
    send_word(KIND_SEND, '1, '1, '1);
    send_word(KIND_ACK, '0, '0, '0);          // hits a slot that was never valid
    send_word(KIND_ACK, '1, '0, '0);
    send_word(KIND_ACK, '1, '0, '0);          // current already acked
  endtask

  task automatic test_store_overflow();
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] t;
    logic [BODY_W-1:0] b;
    gap_max = 2;
    for (int k = 0; k < 19; k++) begin
      id = (k == 0) ? '0 : (k == 1) ? '1 : $urandom;
      // equal low timestamps on every fourth word so eviction has to break ties
      t  = (k % 4 == 0) ? 64'd3 : (k == 1) ? '1 : {$urandom, $urandom} | 64'h8000_0000_0000_0000;
      case (k)
        0: b = '0;
        1: b = '1;
        2: b = 64'hAAAA_AAAA_AAAA_AAAA;
        3: b = 64'h5555_5555_5555_5555;
        default: b = {$urandom, $urandom};
      endcase
      send_word(KIND_SEND, id, t, b);
    end
  endtask

  task automatic test_random_traffic(input logic [LIM_W-1:0] lim, input int unsigned count,
                                     input int unsigned send_pct);
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] t;
    int unsigned       pick;
    set_drain(lim);
    for (int n = 0; n < count; n++) begin
      gap_max = ((n / 12) % 3 == 0) ? 0 : 6;
      pick = $urandom_range(0, 9);
      if ($urandom_range(0, 99) < send_pct) begin
        if (pick < 7 || recent_ids.size() == 0) id = $urandom;
        else if (pick < 9) id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
        else id = $urandom_range(0, 3);
        if ($urandom_range(0, 9) < 6) begin
          clock_stamp += $urandom_range(0, 3);
          t = clock_stamp;
        end else begin
          t = {$urandom, $urandom};
        end
        send_word(KIND_SEND, id, t, {$urandom, $urandom});
      end else begin
        if (pick < 7 && recent_ids.size() != 0)
          id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
        else if (pick < 8) id = live_id;
        else id = $urandom;
        send_word(KIND_ACK, id, {$urandom, $urandom}, {$urandom, $urandom});
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    start       = 1'b0;
    kind_i      = KIND_SEND;
    msg_id_i    = '0;
    msg_time_i  = '0;
    payload_i   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      buf_valid[i] = 1'b0;
      buf_id[i]    = '0;
      buf_time[i]  = '0;
      buf_body[i]  = '0;
    end
    live_valid  = 1'b0;
    live_id     = '0;
    live_time   = '0;
    live_body   = '0;
    drain_reg   = LIM_RST;
    mismatches  = 0;
    gap_max     = 6;
    clock_stamp = 64'd100;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_ack_paths();
    test_store_overflow();
    test_random_traffic(5'd1, 64, 55);
    test_random_traffic(5'd0, 64, 75);
    test_random_traffic(5'd31, 64, 60);
    test_random_traffic(5'd17, 64, 80);
    test_random_traffic(5'd5, 64, 50);
    test_random_traffic(LIM_W'($urandom_range(1, 16)), 64, 65);
    test_random_traffic(5'd16, 64, 45);

    settle();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && due_words.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### sim.f
sv/umrb_pkg.sv
sv/umrb_ram.sv
sv/unacked_message_retransmit_buffer.sv
tb/sv/unacked_message_retransmit_buffer_tb.sv
